FILE: rtl/core/rdol_pkg.sv
// Package for the ramped drive offset loop: widths, register and kind codes,
// reset values and the transfer payload structs. No dependencies.
`default_nettype none

package rdol_pkg;

  localparam int FRAC_BITS   = 12;
  localparam int SAMPLE_BITS = 12;

  localparam int KIND_W  = 3;
  localparam int ADC_W   = 12;
  localparam int FT_W    = 16;
  localparam int CT_W    = 8;
  localparam int GAIN_W  = 16;
  localparam int CS_W    = 12;
  localparam int LIM_W   = 12;
  localparam int SCALE_SHIFT = 8;

  localparam int FILT_W  = SAMPLE_BITS + FRAC_BITS;
  localparam int FREQ_W  = FT_W + FRAC_BITS;
  localparam int CUR_W   = CT_W + FRAC_BITS;
  localparam int INTEG_W = LIM_W + FRAC_BITS;
  localparam int SCL_W   = CUR_W + CS_W - SCALE_SHIFT;

  localparam int MAX_A   = (FREQ_W > FILT_W) ? FREQ_W : FILT_W;
  localparam int MAX_B   = (MAX_A > SCL_W) ? MAX_A : SCL_W;
  localparam int DIFF_W  = ((MAX_B > CUR_W) ? MAX_B : CUR_W) + 2;
  localparam int PROD_W  = CUR_W + CS_W + 1;
  localparam int ACC_W   = (PROD_W > DIFF_W + 1) ? PROD_W : DIFF_W + 1;
  localparam int CNT_W   = $clog2(GAIN_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FREQ_TARGET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_TARGET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_GAIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_SCALE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LIMIT   = 3'd6;

  localparam logic [KIND_W-1:0] KIND_TICK       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DRIVER_ON  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DRIVER_OFF = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OFFSET_ON  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OFFSET_OFF = 3'd4;

  localparam logic [GAIN_W-1:0] FILTER_GAIN_RST   = 16'd6554;
  localparam logic [GAIN_W-1:0] RAMP_GAIN_RST     = 16'd3277;
  localparam logic [GAIN_W-1:0] INTEGRAL_GAIN_RST = 16'd3277;
  localparam logic [CS_W-1:0]   CURRENT_SCALE_RST = 12'd1997;
  localparam logic [LIM_W-1:0]  OFFSET_LIMIT_RST  = 12'd2500;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADC_W-1:0]  adc_sample;
  } in_item_t;

  typedef struct packed {
    logic [15:0] freq_pwm;
    logic [7:0]  pot_level;
    logic [11:0] offset_pwm;
    logic [11:0] filtered_phase;
    logic [11:0] filtered_current;
    logic        next_channel;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/ramped_drive_offset_loop.sv
// Ramped drive offset loop: feedback filters, setpoint ramps, offset integrator.
// Uses rdol_pkg for widths, codes and payload structs.
//
// Usage:
//   in_valid/in_ready/in_data carry one item (kind, adc_sample); out_valid/
//   out_ready/out_data carry exactly one result per item. cfg_valid/cfg_index/
//   cfg_data write a register (cfg_ready is always high); write only when idle.
//   All multiplies go through one shared shift-add unit that consumes one gain
//   bit per cycle, with an operand load state before each multiply.
//   Event items (kinds 1..7) skip the multiplier and go straight to the done state.
//   Tick items run the filter, then the two ramps if the driver is on, then scale
//   and then integrate if the offset loop is on.
//   One item is in work at a time; in_ready is high while no item is in work.
//   A finished result sits in the output register, so the next item can be
//   taken while it waits; if the receiver still stalls when that next item
//   finishes, the block holds it until out_ready.
//   Reset (rst_n low at a clock edge) restores register defaults, clears all
//   filter, ramp and integrator state, and empties the output register.
`default_nettype none

module ramped_drive_offset_loop (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  rdol_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  wire                         out_ready,
  output rdol_pkg::out_item_t         out_data,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire [rdol_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [rdol_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rdol_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [2:0] OP_FILT  = 3'd0;
  localparam logic [2:0] OP_FREQ  = 3'd1;
  localparam logic [2:0] OP_CUR   = 3'd2;
  localparam logic [2:0] OP_SCALE = 3'd3;
  localparam logic [2:0] OP_INTEG = 3'd4;

  // configuration
  logic [FT_W-1:0]   ft_r;
  logic [CT_W-1:0]   ct_r;
  logic [GAIN_W-1:0] fg_r, rg_r, ig_r;
  logic [CS_W-1:0]   cs_r;
  logic [LIM_W-1:0]  lim_r;

  // loop state
  logic [1:0]         st_r, st_nxt;
  logic [2:0]         op_r, op_nxt;
  logic               ch_r, ch_nxt;
  logic               drv_r, drv_nxt;
  logic               ofs_r, ofs_nxt;
  logic [FILT_W-1:0]  cf_r, cf_nxt;
  logic [FILT_W-1:0]  pf_r, pf_nxt;
  logic [FREQ_W-1:0]  fr_r, fr_nxt;
  logic [CUR_W-1:0]   cr_r, cr_nxt;
  logic [INTEG_W-1:0] oi_r, oi_nxt;

  // serial multiplier and payload
  logic [SAMPLE_BITS-1:0]    smp_r, smp_nxt;
  logic signed [DIFF_W-1:0]  a_r, a_nxt;
  logic [GAIN_W-1:0]         b_r, b_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [SCL_W-1:0]          scl_r, scl_nxt;
  logic                      ov_r, ov_nxt;
  out_item_t                 od_r, od_nxt;

  logic signed [ACC_W-1:0]   a_ext, addend, step_res;
  logic signed [ACC_W-1:0]   upd, integ_sum;
  logic [INTEG_W-1:0]        lim_fx;
  logic                      in_xfer, last_step;

  assign in_ready  = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign in_xfer   = in_valid && in_ready;
  assign last_step = (cnt_r == '0);

  assign a_ext  = {{(ACC_W-DIFF_W){a_r[DIFF_W-1]}}, a_r};
  assign lim_fx = {lim_r, {FRAC_BITS{1'b0}}};

  always_comb begin
    if (op_r == OP_SCALE) begin
      addend   = b_r[GAIN_W-1] ? a_ext : '0;
      step_res = (acc_r <<< 1) + addend;
    end else begin
      addend   = b_r[0] ? a_ext : '0;
      step_res = (acc_r + addend) >>> 1;
    end
  end

  always_comb begin
    upd = '0;
    case (op_r)
      OP_FILT: upd = $signed(ACC_W'(ch_r ? pf_r : cf_r)) + step_res;
      OP_FREQ: upd = $signed(ACC_W'(fr_r)) + step_res;
      OP_CUR:  upd = $signed(ACC_W'(cr_r)) + step_res;
      default: upd = '0;
    endcase
    integ_sum = $signed(ACC_W'(oi_r)) + step_res;
  end

  always_comb begin
    st_nxt  = st_r;
    op_nxt  = op_r;
    ch_nxt  = ch_r;
    drv_nxt = drv_r;
    ofs_nxt = ofs_r;
    cf_nxt  = cf_r;
    pf_nxt  = pf_r;
    fr_nxt  = fr_r;
    cr_nxt  = cr_r;
    oi_nxt  = oi_r;
    smp_nxt = smp_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    scl_nxt = scl_r;
    ov_nxt  = ov_r && !out_ready;
    od_nxt  = od_r;

    case (st_r)
      ST_IDLE: begin
        if (in_xfer) begin
          smp_nxt = in_data.adc_sample[SAMPLE_BITS-1:0];
          st_nxt  = ST_DONE;
          case (in_data.kind)
            KIND_TICK: begin
              op_nxt = OP_FILT;
              st_nxt = ST_LOAD;
            end
            KIND_DRIVER_ON:  drv_nxt = 1'b1;
            KIND_DRIVER_OFF: begin
              drv_nxt = 1'b0;
              fr_nxt  = '0;
              cr_nxt  = '0;
            end
            KIND_OFFSET_ON:  ofs_nxt = 1'b1;
            KIND_OFFSET_OFF: begin
              ofs_nxt = 1'b0;
              oi_nxt  = '0;
            end
            default: ;
          endcase
        end
      end

      ST_LOAD: begin
        acc_nxt = '0;
        cnt_nxt = CNT_W'(GAIN_W - 1);
        st_nxt  = ST_RUN;
        case (op_r)
          OP_FILT: begin
            a_nxt = $signed(DIFF_W'({smp_r, {FRAC_BITS{1'b0}}}))
                  - $signed(DIFF_W'(ch_r ? pf_r : cf_r));
            b_nxt = fg_r;
          end
          OP_FREQ: begin
            a_nxt = $signed(DIFF_W'({ft_r, {FRAC_BITS{1'b0}}})) - $signed(DIFF_W'(fr_r));
            b_nxt = rg_r;
          end
          OP_CUR: begin
            a_nxt = $signed(DIFF_W'({ct_r, {FRAC_BITS{1'b0}}})) - $signed(DIFF_W'(cr_r));
            b_nxt = rg_r;
          end
          OP_SCALE: begin
            a_nxt   = $signed(DIFF_W'(cr_r));
            b_nxt   = {cs_r, {(GAIN_W-CS_W){1'b0}}};
            cnt_nxt = CNT_W'(CS_W - 1);
          end
          default: begin
            // negated error: filtered current minus scaled ramp
            a_nxt = $signed(DIFF_W'(cf_r)) - $signed(DIFF_W'(scl_r));
            b_nxt = ig_r;
          end
        endcase
      end

      ST_RUN: begin
        acc_nxt = step_res;
        cnt_nxt = cnt_r - 1'b1;
        b_nxt   = (op_r == OP_SCALE) ? (b_r << 1) : (b_r >> 1);
        if (last_step) begin
          st_nxt = ST_LOAD;
          case (op_r)
            OP_FILT: begin
              if (ch_r) begin
                pf_nxt = upd[FILT_W-1:0];
              end else begin
                cf_nxt = upd[FILT_W-1:0];
              end
              ch_nxt = !ch_r;
              if (drv_r) begin
                op_nxt = OP_FREQ;
              end else if (ofs_r) begin
                op_nxt = OP_SCALE;
              end else begin
                st_nxt = ST_DONE;
              end
            end
            OP_FREQ: begin
              fr_nxt = upd[FREQ_W-1:0];
              op_nxt = OP_CUR;
            end
            OP_CUR: begin
              cr_nxt = upd[CUR_W-1:0];
              if (ofs_r) begin
                op_nxt = OP_SCALE;
              end else begin
                st_nxt = ST_DONE;
              end
            end
            OP_SCALE: begin
              scl_nxt = step_res[SCALE_SHIFT +: SCL_W];
              op_nxt  = OP_INTEG;
            end
            default: begin
              if (integ_sum[ACC_W-1]) begin
                oi_nxt = '0;
              end else if (integ_sum > $signed(ACC_W'(lim_fx))) begin
                oi_nxt = lim_fx;
              end else begin
                oi_nxt = integ_sum[INTEG_W-1:0];
              end
              st_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt                  = 1'b1;
          od_nxt.freq_pwm         = fr_r[FREQ_W-1:FRAC_BITS];
          od_nxt.pot_level        = cr_r[CUR_W-1:FRAC_BITS];
          od_nxt.offset_pwm       = oi_r[INTEG_W-1:FRAC_BITS];
          od_nxt.filtered_phase   = pf_r[FILT_W-1:FRAC_BITS];
          od_nxt.filtered_current = cf_r[FILT_W-1:FRAC_BITS];
          od_nxt.next_channel     = ch_r;
          st_nxt                  = ST_IDLE;
        end
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ft_r  <= '0;
      ct_r  <= '0;
      fg_r  <= FILTER_GAIN_RST;
      rg_r  <= RAMP_GAIN_RST;
      ig_r  <= INTEGRAL_GAIN_RST;
      cs_r  <= CURRENT_SCALE_RST;
      lim_r <= OFFSET_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FREQ_TARGET:    ft_r  <= cfg_data[FT_W-1:0];
        REG_CURRENT_TARGET: ct_r  <= cfg_data[CT_W-1:0];
        REG_FILTER_GAIN:    fg_r  <= cfg_data[GAIN_W-1:0];
        REG_RAMP_GAIN:      rg_r  <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_GAIN:  ig_r  <= cfg_data[GAIN_W-1:0];
        REG_CURRENT_SCALE:  cs_r  <= cfg_data[CS_W-1:0];
        REG_OFFSET_LIMIT:   lim_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      op_r  <= OP_FILT;
      ch_r  <= 1'b0;
      drv_r <= 1'b0;
      ofs_r <= 1'b0;
      cf_r  <= '0;
      pf_r  <= '0;
      fr_r  <= '0;
      cr_r  <= '0;
      oi_r  <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      op_r  <= op_nxt;
      ch_r  <= ch_nxt;
      drv_r <= drv_nxt;
      ofs_r <= ofs_nxt;
      cf_r  <= cf_nxt;
      pf_r  <= pf_nxt;
      fr_r  <= fr_nxt;
      cr_r  <= cr_nxt;
      oi_r  <= oi_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r <= smp_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    scl_r <= scl_nxt;
    od_r  <= od_nxt;
  end

`ifndef SYNTHESIS
  // ramps only move while the driver is on
  a_ramps_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !drv_r |-> (fr_r == '0) && (cr_r == '0))
    else $error("ramp state nonzero while driver off");

  a_integ_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !ofs_r |-> (oi_r == '0))
    else $error("integrator nonzero while offset loop off");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (st_r != ST_IDLE))
    else $error("input transfer did not start work");
`endif

endmodule

`default_nettype wire
